// File: design/usc_pkg.sv
// Shared types and constants for the unix-seconds to civil-date converter.
// Used by unix_seconds_to_civil_date_unit, its checkers and the testbench; no dependencies.

package usc_pkg;

    // Pipeline depth: input capture register through output register.
    localparam int NSTG = 14;

    // Field widths.
    localparam int SECS_W  = 32;
    localparam int MINS_W  = 27;   // up to 71582788
    localparam int HOURS_W = 21;   // up to 1193046 plus offset
    localparam int DAYS_W  = 16;   // up to 49710
    localparam int TZ_W    = 5;
    localparam int SEC_W   = 6;
    localparam int MIN_W   = 6;
    localparam int HOUR_W  = 5;
    localparam int DAY_W   = 5;
    localparam int MON_W   = 4;
    localparam int YEAR_W  = 12;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;

    // Result bit positions in m_tdata, lowest field first.
    localparam int SEC_LSB  = 0;
    localparam int MIN_LSB  = SEC_LSB + SEC_W;
    localparam int HOUR_LSB = MIN_LSB + MIN_W;
    localparam int DAY_LSB  = HOUR_LSB + HOUR_W;
    localparam int MON_LSB  = DAY_LSB + DAY_W;
    localparam int YEAR_LSB = MON_LSB + MON_W;
    localparam int DATA_USED = YEAR_LSB + YEAR_W;

    // Reciprocals for divide-by-constant: q0 = (x * floor(2^S / D)) >> S,
    // with x < 2^S, is low by at most one.
    localparam int S_SEC = 32;
    localparam int S_MIN = 27;
    localparam int S_HR  = 21;
    localparam int S_CYC = 18;
    localparam int S_MON = 11;
    localparam int S_DAY = 10;
    localparam logic [26:0] RCP_SEC = 27'((64'd1 << S_SEC) / 64'd60);
    localparam logic [21:0] RCP_MIN = 22'((64'd1 << S_MIN) / 64'd60);
    localparam logic [16:0] RCP_HR  = 17'((64'd1 << S_HR) / 64'd24);
    localparam logic [7:0]  RCP_CYC = 8'((64'd1 << S_CYC) / 64'd1461);
    localparam logic [3:0]  RCP_MON = 4'((64'd1 << S_MON) / 64'd153);
    // Rounded up; exact for remainders below 153.
    localparam logic [7:0]  RCP_DAY = 8'(((64'd1 << S_DAY) + 64'd4) / 64'd5);

    // Julian-day algorithm constants.
    localparam int unsigned JDN_OFS    = 2472632;
    localparam int unsigned DAYS_400Y  = 146097;
    localparam int unsigned DAYS_4Y    = 1461;
    localparam int unsigned DAYS_5MON  = 153;
    localparam int unsigned B_BASE     = 67;      // smallest century index reached
    localparam int unsigned YEAR_BASE  = 6700 - 4800 - 0 * 1900 + 0;  // 100*B_BASE - 4800

    // Start of centuries B_BASE..B_BASE+2, in shifted day numbers.
    localparam logic [21:0] CYC_START0 = 22'(DAYS_400Y * (B_BASE + 0) / 4);
    localparam logic [21:0] CYC_START1 = 22'(DAYS_400Y * (B_BASE + 1) / 4);
    localparam logic [21:0] CYC_START2 = 22'(DAYS_400Y * (B_BASE + 2) / 4);

    localparam logic [3:0] MON_WRAP = 4'd10;

    // Time fields that ride along the pipeline.
    typedef struct packed {
        logic                ok;
        logic [HOUR_W-1:0]   hour;
        logic [MIN_W-1:0]    minute;
        logic [SEC_W-1:0]    second;
    } tm_t;

endpackage

// File: design/unix_seconds_to_civil_date_unit.sv
// Top level: unix seconds to local civil date and time, 14-stage pipeline.
// Depends on usc_pkg.
//
//  channel   direction  payload (low bit first)
//  s_*       in         tdata: unix_seconds[31:0]
//  m_*       out        tdata: second, minute, hour, day, month, year, 2 pad
//                       tuser: valid_res
//  cfg_*     in         cfg_wdata: tz_offset_hours (signed)
//
// One transaction per cycle is accepted while the output side keeps up. Each
// divide-by-constant but the final divide by 5 is a reciprocal multiply stage
// followed by a one-step correction stage; the divide by 5 needs no correction.
// Stages with no item are filled while later stages are stalled, so bubbles
// close up. Reset clears the stage valid bits and the offset register.

module unix_seconds_to_civil_date_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [usc_pkg::IN_TDATA_W-1:0]       s_tdata,   // unix_seconds[31:0]
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // second[5:0], minute[11:6], hour[16:12], day[21:17], month[25:22],
    // year[37:26], zero[39:38]
    output logic [usc_pkg::OUT_TDATA_W-1:0]      m_tdata,
    output logic                                 m_tuser,   // valid_res[0]
    input  logic                                 cfg_we,
    input  logic signed [usc_pkg::TZ_W-1:0]      cfg_wdata
);

    localparam int N = usc_pkg::NSTG;

    logic [N-1:0] v_reg, v_next, en;
    logic signed [usc_pkg::TZ_W-1:0] tz_reg;

    // stage payloads
    logic [31:0] secs1_reg, secs1_next;
    logic [31:0] secs2_reg;
    logic [26:0] qm2_reg, qm2_next;
    logic [26:0] mins3_reg, mins3_next;
    usc_pkg::tm_t tm3_reg, tm3_next;
    logic [26:0] mins4_reg;
    logic [20:0] qh4_reg, qh4_next;
    usc_pkg::tm_t tm4_reg;
    logic [20:0] hours5_reg, hours5_next;
    usc_pkg::tm_t tm5_reg, tm5_next;
    logic [20:0] local6_reg, local6_next;
    usc_pkg::tm_t tm6_reg, tm6_next;
    logic [20:0] local7_reg;
    logic [15:0] qd7_reg, qd7_next;
    usc_pkg::tm_t tm7_reg;
    logic [15:0] days8_reg, days8_next;
    usc_pkg::tm_t tm8_reg, tm8_next;
    logic [15:0] c9_reg, c9_next;
    logic [1:0]  bx9_reg, bx9_next;
    usc_pkg::tm_t tm9_reg;
    logic [15:0] c10_reg;
    logic [6:0]  dq10_reg, dq10_next;
    logic [1:0]  bx10_reg;
    usc_pkg::tm_t tm10_reg;
    logic [8:0]  e11_reg, e11_next;
    logic [6:0]  d11_reg, d11_next;
    logic [1:0]  bx11_reg;
    usc_pkg::tm_t tm11_reg;
    logic [8:0]  e12_reg;
    logic [3:0]  mq12_reg, mq12_next;
    logic [6:0]  d12_reg;
    logic [1:0]  bx12_reg;
    usc_pkg::tm_t tm12_reg;
    logic [3:0]  m13_reg, m13_next;
    logic [7:0]  r13_reg, r13_next;
    logic [6:0]  d13_reg;
    logic [1:0]  bx13_reg;
    usc_pkg::tm_t tm13_reg;
    logic [usc_pkg::OUT_TDATA_W-1:0] odata_reg, odata_next;
    logic ouser_reg, ouser_next;

    // ---------------- handshake and valid bits ----------------
    always_comb
    begin
        en[N-1] = !v_reg[N-1] || m_tready;
        for (int k = N - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
        v_next[0] = en[0] ? s_tvalid : v_reg[0];
        for (int k = 1; k < N; k++)
        begin
            v_next[k] = en[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[N-1];
    assign m_tdata  = odata_reg;
    assign m_tuser  = ouser_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= '0;
            tz_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
            if (cfg_we)
            begin
                tz_reg <= cfg_wdata;
            end
        end
    end

    // ---------------- datapath ----------------
    logic [58:0] pm_sec;
    logic [31:0] rs_full;
    logic [6:0]  rs;
    logic [48:0] pm_min;
    logic [26:0] rm_full;
    logic [6:0]  rm;
    logic signed [21:0] local_s;
    logic [37:0] pm_hr;
    logic [20:0] rh_full;
    logic [5:0]  rh;
    logic [21:0] a_day;
    logic [21:0] c_full;
    logic [17:0] x_cyc;
    logic [25:0] pm_cyc;
    logic [17:0] r_cyc;
    logic [10:0] y_mon;
    logic [14:0] pm_mon;
    logic [10:0] r_mon;
    logic [15:0] pm_day;
    logic [4:0]  dom;
    logic        wrap;
    logic [3:0]  mon;
    logic [11:0] year;

    always_comb
    begin
        secs1_next = s_tdata[31:0];

        // seconds -> minutes
        pm_sec  = 59'(secs1_reg) * 59'(usc_pkg::RCP_SEC);
        qm2_next = pm_sec[58:32];

        rs_full = secs2_reg - 32'(qm2_reg) * 32'd60;
        rs      = rs_full[6:0];
        tm3_next = '0;
        if (rs >= 7'd60)
        begin
            mins3_next      = qm2_reg + 27'd1;
            tm3_next.second = 6'(rs - 7'd60);
        end
        else
        begin
            mins3_next      = qm2_reg;
            tm3_next.second = rs[5:0];
        end

        // minutes -> hours
        pm_min   = 49'(mins3_reg) * 49'(usc_pkg::RCP_MIN);
        qh4_next = pm_min[47:27];

        rm_full = mins4_reg - 27'(qh4_reg) * 27'd60;
        rm      = rm_full[6:0];
        tm5_next = tm4_reg;
        if (rm >= 7'd60)
        begin
            hours5_next     = qh4_reg + 21'd1;
            tm5_next.minute = 6'(rm - 7'd60);
        end
        else
        begin
            hours5_next     = qh4_reg;
            tm5_next.minute = rm[5:0];
        end

        // time-zone shift; negative local hours give an invalid result
        local_s     = signed'({1'b0, hours5_reg}) + 22'(tz_reg);
        local6_next = local_s[20:0];
        tm6_next    = tm5_reg;
        tm6_next.ok = !local_s[21];

        // hours -> days
        pm_hr    = 38'(local6_reg) * 38'(usc_pkg::RCP_HR);
        qd7_next = pm_hr[36:21];

        rh_full = local7_reg - 21'(qd7_reg) * 21'd24;
        rh      = rh_full[5:0];
        tm8_next = tm7_reg;
        if (rh >= 6'd24)
        begin
            days8_next    = qd7_reg + 16'd1;
            tm8_next.hour = 5'(rh - 6'd24);
        end
        else
        begin
            days8_next    = qd7_reg;
            tm8_next.hour = rh[4:0];
        end

        // century: only three centuries are reachable from 32-bit input
        a_day = 22'(days8_reg) + 22'(usc_pkg::JDN_OFS);
        priority if (a_day >= usc_pkg::CYC_START2)
        begin
            bx9_next = 2'd2;
            c_full   = a_day - usc_pkg::CYC_START2;
        end
        else if (a_day >= usc_pkg::CYC_START1)
        begin
            bx9_next = 2'd1;
            c_full   = a_day - usc_pkg::CYC_START1;
        end
        else
        begin
            bx9_next = 2'd0;
            c_full   = a_day - usc_pkg::CYC_START0;
        end
        c9_next = c_full[15:0];

        // 4-year cycles within the century block
        x_cyc     = {c9_reg, 2'b11};
        pm_cyc    = 26'(x_cyc) * 26'(usc_pkg::RCP_CYC);
        dq10_next = pm_cyc[24:18];

        // day of year comes straight from the remainder: e = rem / 4
        r_cyc = {c10_reg, 2'b11} - 18'(dq10_reg) * 18'(usc_pkg::DAYS_4Y);
        if (r_cyc >= 18'(usc_pkg::DAYS_4Y))
        begin
            d11_next = dq10_reg + 7'd1;
            e11_next = 9'((r_cyc - 18'(usc_pkg::DAYS_4Y)) >> 2);
        end
        else
        begin
            d11_next = dq10_reg;
            e11_next = r_cyc[10:2];
        end

        // month from March-based day of year
        y_mon     = 11'(e11_reg) * 11'd5 + 11'd2;
        pm_mon    = 15'(y_mon) * 15'(usc_pkg::RCP_MON);
        mq12_next = pm_mon[14:11];

        r_mon = 11'(e12_reg) * 11'd5 + 11'd2 - 11'(mq12_reg) * 11'(usc_pkg::DAYS_5MON);
        if (r_mon >= 11'(usc_pkg::DAYS_5MON))
        begin
            m13_next = mq12_reg + 4'd1;
            r13_next = 8'(r_mon - 11'(usc_pkg::DAYS_5MON));
        end
        else
        begin
            m13_next = mq12_reg;
            r13_next = r_mon[7:0];
        end

        // day of month is remainder / 5 + 1
        pm_day = 16'(r13_reg) * 16'(usc_pkg::RCP_DAY);
        dom    = 5'(pm_day[14:10] + 5'd1);
        wrap   = m13_reg >= usc_pkg::MON_WRAP;
        mon    = wrap ? 4'(m13_reg - 4'd9) : 4'(m13_reg + 4'd3);
        year   = 12'(usc_pkg::YEAR_BASE) + 12'(bx13_reg) * 12'd100
               + 12'(d13_reg) + 12'(wrap);

        odata_next = '0;
        odata_next[usc_pkg::SEC_LSB +: usc_pkg::SEC_W] = tm13_reg.second;
        odata_next[usc_pkg::MIN_LSB +: usc_pkg::MIN_W] = tm13_reg.minute;
        if (tm13_reg.ok)
        begin
            odata_next[usc_pkg::HOUR_LSB +: usc_pkg::HOUR_W] = tm13_reg.hour;
            odata_next[usc_pkg::DAY_LSB  +: usc_pkg::DAY_W]  = dom;
            odata_next[usc_pkg::MON_LSB  +: usc_pkg::MON_W]  = mon;
            odata_next[usc_pkg::YEAR_LSB +: usc_pkg::YEAR_W] = year;
        end
        ouser_next = tm13_reg.ok;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            secs1_reg <= secs1_next;
        end
        if (en[1])
        begin
            secs2_reg <= secs1_reg;
            qm2_reg   <= qm2_next;
        end
        if (en[2])
        begin
            mins3_reg <= mins3_next;
            tm3_reg   <= tm3_next;
        end
        if (en[3])
        begin
            mins4_reg <= mins3_reg;
            qh4_reg   <= qh4_next;
            tm4_reg   <= tm3_reg;
        end
        if (en[4])
        begin
            hours5_reg <= hours5_next;
            tm5_reg    <= tm5_next;
        end
        if (en[5])
        begin
            local6_reg <= local6_next;
            tm6_reg    <= tm6_next;
        end
        if (en[6])
        begin
            local7_reg <= local6_reg;
            qd7_reg    <= qd7_next;
            tm7_reg    <= tm6_reg;
        end
        if (en[7])
        begin
            days8_reg <= days8_next;
            tm8_reg   <= tm8_next;
        end
        if (en[8])
        begin
            c9_reg  <= c9_next;
            bx9_reg <= bx9_next;
            tm9_reg <= tm8_reg;
        end
        if (en[9])
        begin
            c10_reg  <= c9_reg;
            dq10_reg <= dq10_next;
            bx10_reg <= bx9_reg;
            tm10_reg <= tm9_reg;
        end
        if (en[10])
        begin
            e11_reg  <= e11_next;
            d11_reg  <= d11_next;
            bx11_reg <= bx10_reg;
            tm11_reg <= tm10_reg;
        end
        if (en[11])
        begin
            e12_reg  <= e11_reg;
            mq12_reg <= mq12_next;
            d12_reg  <= d11_reg;
            bx12_reg <= bx11_reg;
            tm12_reg <= tm11_reg;
        end
        if (en[12])
        begin
            m13_reg  <= m13_next;
            r13_reg  <= r13_next;
            d13_reg  <= d12_reg;
            bx13_reg <= bx12_reg;
            tm13_reg <= tm12_reg;
        end
        if (en[13])
        begin
            odata_reg <= odata_next;
            ouser_reg <= ouser_next;
        end
    end

endmodule

// File: design/usc_chk.sv
// Port-level checker for unix_seconds_to_civil_date_unit, bound to the top.
// Depends on usc_pkg.

module usc_chk (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [usc_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input logic                             m_tuser
);

    logic [usc_pkg::SEC_W-1:0]  sec;
    logic [usc_pkg::MIN_W-1:0]  minute;
    logic [usc_pkg::HOUR_W-1:0] hour;
    logic [usc_pkg::DAY_W-1:0]  dom;
    logic [usc_pkg::MON_W-1:0]  mon;
    logic [usc_pkg::YEAR_W-1:0] year;

    assign sec    = m_tdata[usc_pkg::SEC_LSB  +: usc_pkg::SEC_W];
    assign minute = m_tdata[usc_pkg::MIN_LSB  +: usc_pkg::MIN_W];
    assign hour   = m_tdata[usc_pkg::HOUR_LSB +: usc_pkg::HOUR_W];
    assign dom    = m_tdata[usc_pkg::DAY_LSB  +: usc_pkg::DAY_W];
    assign mon    = m_tdata[usc_pkg::MON_LSB  +: usc_pkg::MON_W];
    assign year   = m_tdata[usc_pkg::YEAR_LSB +: usc_pkg::YEAR_W];

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // every valid result is a legal time and date
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> sec < 6'd60 && minute < 6'd60 && hour < 5'd24
        && dom != 5'd0 && mon != 4'd0 && mon <= 4'd12)
        else $error("valid result out of range");

    a_year: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> year >= 12'd1969 && year <= 12'd2106)
        else $error("year out of range");

    // before-epoch results carry only seconds and minutes
    a_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> hour == '0 && dom == '0 && mon == '0 && year == '0
        && sec < 6'd60 && minute < 6'd60)
        else $error("invalid result has date fields set");

endmodule

bind unix_seconds_to_civil_date_unit usc_chk u_usc_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: dv/usc_checker.sv
// Scoreboard for unix_seconds_to_civil_date_unit: watches input, output and
// config channels, computes each expected date/time and compares in order.
// Depends on usc_pkg.

module usc_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [usc_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [usc_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                             m_tuser,
    input  logic                             cfg_we,
    input  logic signed [usc_pkg::TZ_W-1:0]  cfg_wdata,
    output int                               fail_count,
    output int                               open_count
);

    import usc_pkg::*;

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [MON_W-1:0]  month;
        logic [DAY_W-1:0]  day;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
        logic              ok;
    } civil_t;

    civil_t                 due_dates[$];
    logic signed [TZ_W-1:0] tz_hours = '0;
    int                     fails = 0;

    assign fail_count = fails;

    // Julian-day integer method on the shifted day count.
    function automatic civil_t civil_from_secs(logic [31:0] secs,
                                               logic signed [TZ_W-1:0] tz);
        longint unsigned mins, lh, jd, cyc, in_cyc, quad, in_quad, mi, wrap;
        longint          hr_local;
        civil_t          r;
        r        = '0;
        mins     = secs / 60;
        hr_local = longint'(mins / 60) + longint'(tz);
        r.second = SEC_W'(secs % 60);
        r.minute = MIN_W'(mins % 60);
        // local time before the epoch leaves hour and date at zero
        if (hr_local >= 0)
        begin
            lh      = hr_local;
            jd      = lh / 24 + 2472632;
            cyc     = (4 * jd + 3) / 146097;
            in_cyc  = jd - (cyc * 146097) / 4;
            quad    = (4 * in_cyc + 3) / 1461;
            in_quad = in_cyc - (1461 * quad) / 4;
            mi      = (5 * in_quad + 2) / 153;
            wrap    = mi / 10;
            r.hour  = HOUR_W'(lh % 24);
            r.day   = DAY_W'(in_quad - (153 * mi + 2) / 5 + 1);
            r.month = MON_W'(mi + 3 - 12 * wrap);
            r.year  = YEAR_W'(100 * cyc + quad + wrap - 4800);
            r.ok    = 1'b1;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge clk)
    begin : watch
        civil_t want;
        civil_t got;
        if (!rst_n)
        begin
            tz_hours = '0;
            due_dates.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
                due_dates.push_back(civil_from_secs(s_tdata, tz_hours));
            if (m_tvalid && m_tready)
            begin
                got.second = m_tdata[SEC_LSB +: SEC_W];
                got.minute = m_tdata[MIN_LSB +: MIN_W];
                got.hour   = m_tdata[HOUR_LSB +: HOUR_W];
                got.day    = m_tdata[DAY_LSB +: DAY_W];
                got.month  = m_tdata[MON_LSB +: MON_W];
                got.year   = m_tdata[YEAR_LSB +: YEAR_W];
                got.ok     = m_tuser;
                if (due_dates.size() == 0)
                begin
                    $error("result transaction with nothing outstanding: tdata %h", m_tdata);
                    fails++;
                end
                else
                begin
                    want = due_dates.pop_front();
                    check_field("second_of_minute", want.second, got.second);
                    check_field("minute_of_hour", want.minute, got.minute);
                    check_field("hour_of_day", want.hour, got.hour);
                    check_field("day_of_month", want.day, got.day);
                    check_field("month_of_year", want.month, got.month);
                    check_field("full_year", want.year, got.year);
                    check_field("valid_res", want.ok, got.ok);
                    check_field("tdata pad", 0, m_tdata[OUT_TDATA_W-1:DATA_USED]);
                end
            end
            if (cfg_we)
                tz_hours = cfg_wdata;
        end
        open_count <= due_dates.size();
    end

endmodule

// File: dv/tb_top.sv
// Top of the converter testbench: clock, reset, stimulus and verdict.
// Depends on usc_pkg, unix_seconds_to_civil_date_unit and usc_checker.

module tb_top;

    import usc_pkg::*;

    localparam int IDLE_LIMIT = 1000;
    localparam int PHASES     = 8;
    localparam int PER_PHASE  = 135;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata   = '0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    m_tuser;
    logic                    cfg_we    = 1'b0;
    logic signed [TZ_W-1:0]  cfg_wdata = '0;
    logic                    calm      = 1'b0;
    int                      fail_count;
    int                      open_count;
    int                      stall_left   = 0;
    int                      quiet_cycles = 0;
    logic signed [TZ_W-1:0]  tz_plan [PHASES];

    always #1 clk = ~clk;

    unix_seconds_to_civil_date_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    usc_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .open_count (open_count)
    );

    // Output backpressure: random stall bursts, each followed by a ready
    // stretch; none once calm is set.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (calm)
            m_tready <= 1'b1;
        else if (stall_left == 0)
        begin
            if (m_tready && $urandom_range(0, 3) == 0)
            begin
                m_tready   <= 1'b0;
                stall_left <= $urandom_range(0, 7);
            end
            else
            begin
                m_tready   <= 1'b1;
                stall_left <= $urandom_range(0, 15);
            end
        end
        else
            stall_left <= stall_left - 1;
    end

    // Ends the run if no transaction of any kind happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles == IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Mix of small counts, counts near the top, instants around midnight and
    // full-range values.
    function automatic logic [31:0] pick_secs();
        longint unsigned midnight;
        case ($urandom_range(0, 7))
            0: return 32'($urandom_range(0, 20 * 3600));
            1: return 32'hFFFF_FFFF - 32'($urandom_range(0, 400000));
            2, 3:
            begin
                midnight = longint'($urandom_range(1, 49709)) * 86400;
                return 32'(midnight - 3600 + $urandom_range(0, 7200));
            end
            default: return $urandom();
        endcase
    endfunction

    task automatic push_secs(input logic [31:0] secs);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= secs;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic wait_drained();
        do @(posedge clk); while (open_count != 0);
    endtask

    task automatic write_tz(input logic signed [TZ_W-1:0] tz);
        cfg_we    <= 1'b1;
        cfg_wdata <= tz;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [31:0] corner_secs[$] = '{
            32'd0, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
            32'd946684799,     // last second of 1999
            32'd951782400,     // leap day 2000
            32'd951868800,     // March 1, 2000
            32'd4107542399,    // Feb 28, 2100: century year, no leap day
            32'd4107542400,
            32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
            32'hFFFF_FFFF
        };
        // with the most negative offset: first local hours fall before epoch
        logic [31:0] west_secs[$] = '{32'd0, 32'd57599, 32'd57600, 32'hFFFF_FFFF};

        tz_plan = '{5'sd0, -5'sd16, 5'sd15, -5'sd12, 5'sd14, 5'sd0, 5'sd0, 5'sd0};
        tz_plan[5] = TZ_W'($urandom());
        tz_plan[6] = TZ_W'($urandom());

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // phase 0 runs on the reset offset; later phases write a new one
        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                wait_drained();
                write_tz(tz_plan[p]);
            end
            if (p == PHASES - 1)
                calm <= 1'b1;
            if (p == 0)
                foreach (corner_secs[i]) push_secs(corner_secs[i]);
            if (p == 1)
                foreach (west_secs[i]) push_secs(west_secs[i]);
            if (p == 2)
                push_secs(32'hFFFF_FFFF);
            repeat (PER_PHASE) push_secs(pick_secs());
            s_tvalid <= 1'b0;
        end

        wait_drained();
        repeat (NSTG + 4) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
